// ===== design/fec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fec_pkg
// Shared widths, defaults and verdict codes for the expansion check.
// ----------------------------------------------------------------------------
package fec_pkg;

    localparam int NUM_W         = 31;
    localparam int DEN_W         = 13;
    localparam int RADIX_W       = 8;
    localparam int VERDICT_W     = 2;
    localparam int BIT_CNT_W     = $clog2(NUM_W);
    localparam int RADIX_IDX_W   = $clog2(RADIX_W);
    localparam int MAX_DENOM_DEF = 4096;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FINITE   = 2'd0,
        VERDICT_PERIODIC = 2'd1,
        VERDICT_INVALID  = 2'd2
    } verdict_t;

endpackage

`default_nettype wire

// ===== design/fec_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fec_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/fec_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fec_mod_unit
// Modular double-and-add step: result = (2*acc + addend) mod den,
// for acc and addend already below den.
// ----------------------------------------------------------------------------
module fec_mod_unit (
    input  wire logic [fec_pkg::DEN_W-1:0] acc,
    input  wire logic [fec_pkg::DEN_W-1:0] addend,
    input  wire logic [fec_pkg::DEN_W-1:0] den,
    output logic      [fec_pkg::DEN_W-1:0] result
);

    logic [fec_pkg::DEN_W:0]   dbl;
    logic [fec_pkg::DEN_W:0]   den_ext;
    logic [fec_pkg::DEN_W:0]   red1;
    logic [fec_pkg::DEN_W:0]   sum;
    logic [fec_pkg::DEN_W:0]   red2;

    always_comb
    begin
        den_ext = {1'b0, den};
        dbl     = {acc, 1'b0};
        red1    = (dbl >= den_ext) ? (dbl - den_ext) : dbl;
        sum     = red1 + {1'b0, addend};
        red2    = (sum >= den_ext) ? (sum - den_ext) : sum;
        result  = red2[fec_pkg::DEN_W-1:0];
    end

endmodule

`default_nettype wire

// ===== design/fraction_expansion_finite_check_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_expansion_finite_check_top
// Decides whether numerator/denominator has a finite expansion in base radix
// by stepping remainders through a shared modular unit and a visited bitmap.
// ----------------------------------------------------------------------------
// Invalid denominator: the verdict strobes in the cycle after start.
// Otherwise: bitmap clear over entries 0 to den-1, bit-serial num mod den, then
//   per remainder step a bit-serial radix multiply-mod, bitmap read and check;
//   a step that reaches zero ends after the multiply; at most den steps.
// One item at a time; busy is high until the verdict strobe, which cannot stall.
// Reset: idle, radix = 10; bitmap is cleared per item, so no pass after reset.
module fraction_expansion_finite_check_top #(
    parameter int MAX_DENOM = fec_pkg::MAX_DENOM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [fec_pkg::NUM_W-1:0]       numerator,
    input  wire logic [fec_pkg::DEN_W-1:0]       denominator,
    output logic                                 done,
    output logic      [fec_pkg::VERDICT_W-1:0]   verdict,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fec_pkg::RADIX_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(MAX_DENOM);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MARK  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_CHECK = 7'b1000000
    } state_t;

    state_t                              state_reg,   state_next;
    logic                                done_reg,    done_next;
    logic [fec_pkg::RADIX_W-1:0]         radix_reg,   radix_next;
    fec_pkg::verdict_t                   verdict_reg, verdict_next;
    logic [fec_pkg::NUM_W-1:0]           num_reg,     num_next;
    logic [fec_pkg::DEN_W-1:0]           den_reg,     den_next;
    logic [fec_pkg::DEN_W-1:0]           acc_reg,     acc_next;
    logic [fec_pkg::DEN_W-1:0]           rem_reg,     rem_next;
    logic [fec_pkg::DEN_W-1:0]           clr_reg,     clr_next;
    logic [fec_pkg::BIT_CNT_W-1:0]       bit_reg,     bit_next;

    logic [fec_pkg::DEN_W-1:0]           unit_addend;
    logic [fec_pkg::DEN_W-1:0]           unit_result;
    logic                                ram_wr_en;
    logic [ADDR_W-1:0]                   ram_wr_addr;
    logic [0:0]                          ram_wr_data;
    logic [0:0]                          ram_rd_data;
    logic                                den_bad;

    fec_mod_unit u_mod (
        .acc    (acc_reg),
        .addend (unit_addend),
        .den    (den_reg),
        .result (unit_result)
    );

    fec_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DENOM)
    ) u_seen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ADDR_W'(rem_reg)),
        .rd_data (ram_rd_data)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign cfg_ready = 1'b1;
    assign den_bad   = (denominator == '0) || (32'(denominator) > 32'(MAX_DENOM));

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        radix_next   = radix_reg;
        verdict_next = verdict_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        clr_next     = clr_reg;
        bit_next     = bit_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = ADDR_W'(rem_reg);
        ram_wr_data  = 1'b1;
        unit_addend  = '0;

        if (cfg_valid && cfg_ready)
        begin
            radix_next = cfg_data;
        end

        if (state_reg == S_DIV)
        begin
            unit_addend = fec_pkg::DEN_W'(num_reg[bit_reg]);
        end
        else if (radix_reg[bit_reg[fec_pkg::RADIX_IDX_W-1:0]])
        begin
            unit_addend = rem_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    num_next = numerator;
                    den_next = denominator;
                    rem_next = '0;
                    clr_next = '0;
                    if (den_bad)
                    begin
                        done_next    = 1'b1;
                        verdict_next = fec_pkg::VERDICT_INVALID;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(clr_reg);
                ram_wr_data = 1'b0;
                if (clr_reg == den_reg - fec_pkg::DEN_W'(1))
                begin
                    state_next = S_DIV;
                    acc_next   = '0;
                    bit_next   = fec_pkg::BIT_CNT_W'(fec_pkg::NUM_W - 1);
                end
                else
                begin
                    clr_next = clr_reg + fec_pkg::DEN_W'(1);
                end
            end
            S_DIV:
            begin
                acc_next = unit_result;
                if (bit_reg == '0)
                begin
                    rem_next   = unit_result;
                    state_next = S_MARK;
                end
                else
                begin
                    bit_next = bit_reg - fec_pkg::BIT_CNT_W'(1);
                end
            end
            S_MARK:
            begin
                ram_wr_en  = 1'b1;
                acc_next   = '0;
                bit_next   = fec_pkg::BIT_CNT_W'(fec_pkg::RADIX_W - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next = unit_result;
                if (bit_reg == '0)
                begin
                    rem_next = unit_result;
                    if (unit_result == '0)
                    begin
                        done_next    = 1'b1;
                        verdict_next = fec_pkg::VERDICT_FINITE;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    bit_next = bit_reg - fec_pkg::BIT_CNT_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ram_rd_data[0])
                begin
                    done_next    = 1'b1;
                    verdict_next = fec_pkg::VERDICT_PERIODIC;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    acc_next   = '0;
                    bit_next   = fec_pkg::BIT_CNT_W'(fec_pkg::RADIX_W - 1);
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            radix_reg <= fec_pkg::RADIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            radix_reg <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        clr_reg     <= clr_next;
        bit_reg     <= bit_next;
    end

endmodule

`default_nettype wire
